>>> hw/rtl/aes_pkg.sv
// Shared types, constants and byte-substitution functions for the AES-128 block cipher.
// Used by the column cells, the key schedule and the top level; depends on nothing.
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_ROWS = ROUND_COUNT + 1;
    localparam int STEP_W = $clog2(KEY_ROWS);

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic {
        ENG_IDLE,
        ENG_RUN
    } aes_eng_state_t;

    typedef struct packed {
        logic dec;
        logic bypass;
        logic mix;
    } aes_cell_ctrl_t;

    localparam logic [2047:0] SBOX_TABLE = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] INV_SBOX_TABLE = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TABLE[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_TABLE[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

>>> hw/rtl/aes_col_cell.sv
// One column cell of the round chain: byte substitution, column mixing and round key addition.
// Depends on aes_pkg for the S-box tables, xtime and the cell control struct.
module aes_col_cell (
    input  aes_pkg::aes_cell_ctrl_t ctrl,
    input  logic [31:0]             col_in,
    input  logic [31:0]             key_word,
    output logic [31:0]             col_out
);
    import aes_pkg::*;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ p;
            end
            p = xtime(p);
        end
        return acc;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] a [4];
        logic [7:0] m [4];
        logic [31:0] res;
        m[0] = inv ? 8'd14 : 8'd2;
        m[1] = inv ? 8'd11 : 8'd3;
        m[2] = inv ? 8'd13 : 8'd1;
        m[3] = inv ? 8'd9 : 8'd1;
        for (int k = 0; k < 4; k++) begin
            a[k] = c[31-8*k -: 8];
        end
        for (int r = 0; r < 4; r++) begin
            res[31-8*r -: 8] = gmul(a[r], m[0]) ^ gmul(a[(r+1)%4], m[1])
                             ^ gmul(a[(r+2)%4], m[2]) ^ gmul(a[(r+3)%4], m[3]);
        end
        return res;
    endfunction

    logic [31:0] sub_col;
    logic [31:0] enc_col;
    logic [31:0] dec_sum;
    logic [31:0] dec_col;

    always_comb
    begin
        for (int r = 0; r < 4; r++) begin
            sub_col[31-8*r -: 8] = ctrl.dec ? inv_sbox(col_in[31-8*r -: 8])
                                            : sbox(col_in[31-8*r -: 8]);
        end
        enc_col = (ctrl.mix ? mix_col(sub_col, 1'b0) : sub_col) ^ key_word;
        dec_sum = sub_col ^ key_word;
        dec_col = ctrl.mix ? mix_col(dec_sum, 1'b1) : dec_sum;
        if (ctrl.bypass) begin
            col_out = col_in ^ key_word;
        end else if (ctrl.dec) begin
            col_out = dec_col;
        end else begin
            col_out = enc_col;
        end
    end

endmodule

>>> hw/rtl/aes_key_sched.sv
// Key schedule: expands the cipher key into eleven round keys, one per cycle, and holds them.
// Depends on aes_pkg for the S-box, xtime, the round count and the key store sizes.
module aes_key_sched (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [127:0]                key_in,
    input  logic                        rd_en,
    input  logic [aes_pkg::STEP_W-1:0]  rd_addr,
    output logic [127:0]                rd_data,
    output logic                        busy
);
    import aes_pkg::*;

    logic [127:0]      key_mem [KEY_ROWS];
    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [127:0]      prev_reg;
    logic [127:0]      prev_next;
    logic [7:0]        rc_reg;
    logic [7:0]        rc_next;
    logic [127:0]      rd_data_reg;
    logic [31:0]       rot_word;
    logic [31:0]       sub_word;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic [31:0]       w2;
    logic [31:0]       w3;

    always_comb
    begin
        rot_word = {prev_reg[23:0], prev_reg[31:24]};
        for (int b = 0; b < 4; b++) begin
            sub_word[31-8*b -: 8] = sbox(rot_word[31-8*b -: 8]);
        end
        w0 = prev_reg[127:96] ^ sub_word ^ {rc_reg, 24'h000000};
        w1 = w0 ^ prev_reg[95:64];
        w2 = w1 ^ prev_reg[63:32];
        w3 = w2 ^ prev_reg[31:0];
        if (cnt_reg == '0) begin
            prev_next = key_in;
            rc_next = 8'h01;
        end else begin
            prev_next = {w0, w1, w2, w3};
            rc_next = xtime(rc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == STEP_W'(ROUND_COUNT)) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start) begin
            key_mem[cnt_reg] <= prev_next;
            prev_reg <= prev_next;
            rc_reg <= rc_next;
        end
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy = busy_reg;

endmodule

>>> hw/rtl/aes128_block_cipher.sv
// Top level of the AES-128 ECB block cipher: APB key registers, key schedule and round chain.
// Depends on aes_pkg, aes_key_sched and aes_col_cell.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  config    | psel, penable, pwrite      | paddr, pwdata, prdata
//  item in   | item_valid, item_stall     | opcode, block_high, block_low
//  result    | result_valid, result_stall | result_high, result_low
//
// An item takes one whitening step and ten rounds through the row of four column cells,
// one step per cycle but for a stalled last round, paced by the one-row round key read per step.
// The next item is accepted in the cycle after the result is registered.
// A key write starts an expansion into the round key store; items stall meanwhile.
// The round key store is not cleared by reset and must be filled by a key write first.
// A stalled result holds the last round until the output register is free.
module aes128_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        opcode,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import aes_pkg::*;

    logic [63:0]       key_high_reg;
    logic [63:0]       key_low_reg;
    logic              cfg_write;
    logic              key_busy;
    logic              key_rd_en;
    logic [STEP_W-1:0] key_rd_addr;
    logic [127:0]      key_row;

    aes_eng_state_t    state_reg;
    aes_eng_state_t    state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_inc;
    logic              dec_reg;
    logic [127:0]      data_reg;
    logic [127:0]      cell_in;
    logic [127:0]      cell_out;
    logic              accept_in;
    logic              last_step;
    logic              advance;
    logic              finish;
    logic              result_valid_reg;
    logic [127:0]      result_reg;
    aes_cell_ctrl_t    cell_ctrl;

    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[3] ? key_low_reg : key_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[3]) begin
                key_low_reg <= pwdata;
            end else begin
                key_high_reg <= pwdata;
            end
        end
    end

    aes_key_sched u_key_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_write),
        .key_in  ({key_high_reg, key_low_reg}),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_row),
        .busy    (key_busy)
    );

    assign item_stall = (state_reg != ENG_IDLE) || key_busy;
    assign accept_in = item_valid && !item_stall;
    assign last_step = (step_reg == STEP_W'(ROUND_COUNT));
    assign advance = !(last_step && result_valid_reg && result_stall);
    assign finish = (state_reg == ENG_RUN) && last_step && advance;
    assign step_inc = step_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (accept_in) begin
                    state_next = ENG_RUN;
                end
            end
            ENG_RUN: begin
                if (finish) begin
                    state_next = ENG_IDLE;
                end
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    always_comb
    begin
        key_rd_en = 1'b0;
        key_rd_addr = '0;
        unique case (state_reg)
            ENG_IDLE: begin
                key_rd_en = accept_in;
                key_rd_addr = (opcode == OP_DECRYPT) ? STEP_W'(ROUND_COUNT) : '0;
            end
            ENG_RUN: begin
                key_rd_en = advance && !last_step;
                key_rd_addr = (dec_reg == OP_DECRYPT) ? STEP_W'(ROUND_COUNT) - step_inc
                                                      : step_inc;
            end
            default: begin
                key_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ENG_IDLE;
            step_reg <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept_in) begin
                step_reg <= '0;
            end else if ((state_reg == ENG_RUN) && advance && !last_step) begin
                step_reg <= step_inc;
            end
            if (finish) begin
                result_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in) begin
            data_reg <= {block_high, block_low};
            dec_reg <= opcode;
        end else if ((state_reg == ENG_RUN) && advance) begin
            data_reg <= cell_out;
        end
        if (finish) begin
            result_reg <= cell_out;
        end
    end

    assign cell_ctrl.dec = dec_reg;
    assign cell_ctrl.bypass = (step_reg == '0);
    assign cell_ctrl.mix = !last_step;

    for (genvar c = 0; c < 4; c++) begin : g_col
        for (genvar r = 0; r < 4; r++) begin : g_row
            localparam int SRC_ENC = (c + r) % 4;
            localparam int SRC_DEC = (c - r + 4) % 4;
            always_comb
            begin
                if (cell_ctrl.bypass) begin
                    cell_in[127-32*c-8*r -: 8] = data_reg[127-32*c-8*r -: 8];
                end else if (dec_reg == OP_DECRYPT) begin
                    cell_in[127-32*c-8*r -: 8] = data_reg[127-32*SRC_DEC-8*r -: 8];
                end else begin
                    cell_in[127-32*c-8*r -: 8] = data_reg[127-32*SRC_ENC-8*r -: 8];
                end
            end
        end
        aes_col_cell u_cell (
            .ctrl     (cell_ctrl),
            .col_in   (cell_in[127-32*c -: 32]),
            .key_word (key_row[127-32*c -: 32]),
            .col_out  (cell_out[127-32*c -: 32])
        );
    end

    assign result_valid = result_valid_reg;
    assign result_high = result_reg[127:64];
    assign result_low = result_reg[63:0];

endmodule

>>> hw/rtl/aes_checker.sv
// Port-level checker for the AES-128 block cipher, bound to the top level.
// Depends only on the top-level ports.
module aes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [63:0] result_high,
    input logic [63:0] result_low
);

    // A held result keeps its value until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_high) && $stable(result_low))
        else $error("result changed while stalled");

    // An accepted item keeps the engine busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken again right after an item");

    // A key write starts the expansion, which blocks new items.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> item_stall)
        else $error("items not blocked during key expansion");

    // A new result only appears at the end of work, while input was blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall))
        else $error("result without work in progress");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_high  (result_high),
    .result_low   (result_low)
);

>>> bench/tb_aes128_block_cipher.sv
// Self-checking testbench for the AES-128 ECB block cipher: directed vectors, then random items.
// Holds its own AES-128 predictor and key schedule; depends on aes_pkg and aes128_block_cipher.
`timescale 1ns / 1ps

module tb_aes128_block_cipher;
    import aes_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
    localparam logic [3:0] ADDR_KEY_LOW = 4'h8;

    typedef struct {
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic        op;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        bit          known;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } vector_t;

    typedef logic [7:0] state_t[16];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        opcode = OP_ENCRYPT;
    logic [63:0] block_high = '0;
    logic [63:0] block_low = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;

    logic [7:0]   sub_tab[256];
    logic [7:0]   inv_sub_tab[256];
    logic [31:0]  sched_words[44];
    logic [63:0]  cur_key_hi = '0;
    logic [63:0]  cur_key_lo = '0;
    logic [127:0] pending_blocks[$];
    vector_t      vectors[$];

    bit          item_known = 1'b0;
    logic [63:0] item_exp_hi = '0;
    logic [63:0] item_exp_lo = '0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    aes128_block_cipher dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'd27 : 8'd0);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inv(logic [7:0] x);
        logic [7:0] r;
        r = 8'd1;
        for (int i = 0; i < 254; i++)
            r = gf_mul(r, x);
        return x == 8'd0 ? 8'd0 : r;
    endfunction

    function automatic logic [7:0] rotl(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [31:0] sub_word(logic [31:0] w);
        return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'd1;
        sched_words[0] = cur_key_hi[63:32];
        sched_words[1] = cur_key_hi[31:0];
        sched_words[2] = cur_key_lo[63:32];
        sched_words[3] = cur_key_lo[31:0];
        for (int i = 4; i < 44; i++)
        begin
            t = sched_words[i - 1];
            if (i % 4 == 0)
            begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'd0};
                rcon = gf_mul(rcon, 8'd2);
            end
            sched_words[i] = sched_words[i - 4] ^ t;
        end
    endfunction

    function automatic void mix_cols(inout logic [7:0] st[16], input logic [7:0] mat[4]);
        logic [7:0] col[4];
        logic [7:0] v;
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 4; k++)
                col[k] = st[4 * c + k];
            for (int row = 0; row < 4; row++)
            begin
                v = '0;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(col[k], mat[(k - row + 4) % 4]);
                st[4 * c + row] = v;
            end
        end
    endfunction

    function automatic state_t mix_all(state_t st, logic [7:0] mat[4]);
        mix_cols(st, mat);
        return st;
    endfunction

    function automatic logic [127:0] cipher_block(logic op, logic [127:0] blk);
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] mat[4];
        logic [127:0] res;
        int r;
        if (op == OP_DECRYPT)
            mat = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            mat = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int i = 0; i < 16; i++)
            st[i] = blk[127 - 8 * i -: 8];
        for (int step = 0; step <= ROUND_COUNT; step++)
        begin
            r = (op == OP_DECRYPT) ? ROUND_COUNT - step : step;
            if (step != 0)
            begin
                tmp = st;
                for (int row = 0; row < 4; row++)
                    for (int c = 0; c < 4; c++)
                        if (op == OP_DECRYPT)
                            st[row + 4 * ((c + row) % 4)] = inv_sub_tab[tmp[row + 4 * c]];
                        else
                            st[row + 4 * c] = sub_tab[tmp[row + 4 * ((c + row) % 4)]];
                if (op == OP_ENCRYPT && step != ROUND_COUNT)
                    st = mix_all(st, mat);
            end
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    st[4 * c + k] ^= sched_words[4 * r + c][31 - 8 * k -: 8];
            if (op == OP_DECRYPT && step != 0 && step != ROUND_COUNT)
                st = mix_all(st, mat);
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    task automatic write_key(logic [3:0] addr, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_KEY_HIGH)
            cur_key_hi = value;
        else
            cur_key_lo = value;
        build_schedule();
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(logic op, logic [63:0] hi, logic [63:0] lo, bit known,
                             logic [63:0] ehi, logic [63:0] elo);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_valid <= 1'b1;
        opcode <= op;
        block_high <= hi;
        block_low <= lo;
        item_known <= known;
        item_exp_hi <= ehi;
        item_exp_lo <= elo;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_vector(logic [63:0] kh, logic [63:0] kl, logic op,
                                       logic [63:0] bh, logic [63:0] bl, bit known,
                                       logic [63:0] eh, logic [63:0] el);
        vectors.push_back('{kh, kl, op, bh, bl, known, eh, el});
    endfunction

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_blocks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result %h_%h", result_high, result_low);
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (result_high !== want[127:64] || result_low !== want[63:0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h_%h, got %h_%h",
                                     want[127:64], want[63:0], result_high, result_low);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item_known)
                    pending_blocks.push_back({item_exp_hi, item_exp_lo});
                else
                    pending_blocks.push_back(cipher_block(opcode, {block_high, block_low}));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] kh;
        logic [63:0] kl;
        logic        op;
        for (int x = 0; x < 256; x++)
        begin
            kh[7:0] = gf_inv(8'(x));
            sub_tab[x] = kh[7:0] ^ rotl(kh[7:0], 1) ^ rotl(kh[7:0], 2) ^ rotl(kh[7:0], 3)
                         ^ rotl(kh[7:0], 4) ^ 8'h63;
        end
        for (int x = 0; x < 256; x++)
            inv_sub_tab[sub_tab[x]] = 8'(x);

        add_vector('0, '0, OP_ENCRYPT, '0, '0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
        add_vector('0, '0, OP_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, '0, '0);
        add_vector('0, '0, OP_ENCRYPT, '1, '1, 0, '0, '0);
        add_vector('0, '0, OP_DECRYPT, '1, '1, 0, '0, '0);
        add_vector('0, '0, OP_DECRYPT, '0, '0, 0, '0, '0);
        add_vector(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT,
                   64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                   64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        add_vector(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_DECRYPT,
                   64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
                   64'h0011223344556677, 64'h8899aabbccddeeff);
        add_vector(64'h0001020304050607, 64'h08090a0b0c0d0e0f, OP_ENCRYPT,
                   64'h8000000000000000, 64'h0000000000000001, 0, '0, '0);
        add_vector('1, '1, OP_ENCRYPT, '0, '0, 0, '0, '0);
        add_vector('1, '1, OP_ENCRYPT, '1, '1, 0, '0, '0);
        add_vector('1, '1, OP_DECRYPT, '1, '1, 0, '0, '0);
        add_vector('1, '1, OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 0, '0, '0);
        add_vector('1, '0, OP_ENCRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0, '0, '0);
        add_vector('0, '1, OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vectors[i])
        begin
            if (i == 0 || vectors[i].key_hi !== cur_key_hi || vectors[i].key_lo !== cur_key_lo)
            begin
                item_valid <= 1'b0;
                drain();
                write_key(ADDR_KEY_HIGH, vectors[i].key_hi);
                write_key(ADDR_KEY_LOW, vectors[i].key_lo);
            end
            send_item(vectors[i].op, vectors[i].blk_hi, vectors[i].blk_lo, vectors[i].known,
                      vectors[i].exp_hi, vectors[i].exp_lo);
        end

        for (int phase = 0; phase < 14; phase++)
        begin
            item_valid <= 1'b0;
            drain();
            case (phase % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 73; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 73; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            kh = pick_word();
            kl = pick_word();
            case ($urandom_range(2))
                0: write_key(ADDR_KEY_HIGH, kh);
                1: write_key(ADDR_KEY_LOW, kl);
                default:
                begin
                    write_key(ADDR_KEY_LOW, kl);
                    write_key(ADDR_KEY_HIGH, kh);
                end
            endcase
            for (int n = 0; n < 100; n++)
            begin
                op = 1'($urandom_range(1));
                send_item(op, pick_word(), pick_word(), 0, '0, '0);
            end
        end

        item_valid <= 1'b0;
        stall_pct = 0;
        drain();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_col_cell.sv
hw/rtl/aes_key_sched.sv
hw/rtl/aes128_block_cipher.sv
hw/rtl/aes_checker.sv
bench/tb_aes128_block_cipher.sv
